// File: rtl/sorted_list_insert_delete_assert.svh
// Assertion macros for the sorted list block.
// Used by the port checker; needs nothing else.
`ifndef SORTED_LIST_INSERT_DELETE_ASSERT_SVH
`define SORTED_LIST_INSERT_DELETE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SLI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sli_pkg.sv
// Shared constants, codes and types for the sorted list block.
// Used by the controller, the datapath, the top level and the checker.
package sli_pkg;

  // List depth and derived widths.
  localparam int DEPTH   = 16;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int INDEX_W = 4;
  localparam int VALUE_W = 32;

  // Operation codes; the fourth code is unused.
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2
  } opcode_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

  // Controller states.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
  } sli_cmd_t;

endpackage

// File: rtl/sorted_list_insert_delete.sv
// Top level of the sorted list block: joins controller and datapath.
// Depends on sli_pkg, sli_ctrl and sli_datapath.
//
//   Channel   Direction  Handshake              Payload
//   input     in         in_valid_i/in_stall_o  opcode_i, value_i, index_i
//   output    out        out_valid_o/out_stall_i status_o, read_value_o, count_o
//
// Each item passes two steps: the beat is captured, then the entry row is updated.
// The row is compared in parallel in the update cycle and shifts by one place.
// Reset empties the list at once; entry contents are undefined until written.
// A new beat is taken while a result waits; the update cycle holds while the
// output register is occupied and stalled.
module sorted_list_insert_delete (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          opcode_i,
  input  logic signed [sli_pkg::VALUE_W-1:0]  value_i,
  input  logic [sli_pkg::INDEX_W-1:0]         index_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          status_o,
  output logic signed [sli_pkg::VALUE_W-1:0]  read_value_o,
  output logic [sli_pkg::CNT_W-1:0]           count_o
);
  import sli_pkg::*;

  sli_cmd_t cmd;

  // Sequencing and handshakes.
  sli_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Entry row and result.
  sli_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .opcode_i     (opcode_i),
    .value_i      (value_i),
    .index_i      (index_i),
    .status_o     (status_o),
    .read_value_o (read_value_o),
    .count_o      (count_o)
  );

endmodule

// File: rtl/sli_ctrl.sv
// Controller for the sorted list block: handshakes and sequencing.
// Depends on sli_pkg.
module sli_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sli_pkg::sli_cmd_t cmd_o
);
  import sli_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // State and output-valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The output register can take a new beat when empty or being drained.
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          cmd_o.exec  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/sli_datapath.sv
// Datapath for the sorted list block: item capture, entry row, result register.
// Depends on sli_pkg.
module sli_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sli_pkg::sli_cmd_t                   cmd_i,
  input  logic [1:0]                          opcode_i,
  input  logic signed [sli_pkg::VALUE_W-1:0]  value_i,
  input  logic [sli_pkg::INDEX_W-1:0]         index_i,
  output logic [1:0]                          status_o,
  output logic signed [sli_pkg::VALUE_W-1:0]  read_value_o,
  output logic [sli_pkg::CNT_W-1:0]           count_o
);
  import sli_pkg::*;

  // Captured item.
  logic [1:0]                 opcode_q;
  logic signed [VALUE_W-1:0]  value_q;
  logic [INDEX_W-1:0]         index_q;

  // Entry row and fill count.
  logic signed [VALUE_W-1:0]  entries_q [DEPTH];
  logic signed [VALUE_W-1:0]  entries_d [DEPTH];
  logic [CNT_W-1:0]           count_q, count_d;

  // Result register.
  logic [1:0]                 status_q, status_d;
  logic signed [VALUE_W-1:0]  rdval_q, rdval_d;
  logic [CNT_W-1:0]           cnt_out_q;

  // Per-entry compare results.
  logic [DEPTH-1:0]           le;
  logic [DEPTH-1:0]           eq;
  logic [DEPTH:0]             hit_pre;
  logic                       full;

  // Capture the item on an accepted beat.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      opcode_q <= opcode_i;
      value_q  <= value_i;
      index_q  <= index_i;
    end
  end

  // Parallel compares across the row; le forms a prefix as the row is sorted.
  always_comb begin
    hit_pre[0] = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      le[i]        = (CNT_W'(i) < count_q) && (entries_q[i] <= value_q);
      eq[i]        = (CNT_W'(i) < count_q) && (entries_q[i] == value_q);
      hit_pre[i+1] = hit_pre[i] | eq[i];
    end
  end

  assign full = (count_q == CNT_W'(DEPTH));

  // Next row, count and result.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      entries_d[i] = entries_q[i];
    end
    count_d  = count_q;
    status_d = ST_RANGE;
    rdval_d  = '0;
    case (opcode_q)
      OP_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          // Each cell keeps, takes the value, or takes its lower neighbour.
          if (!le[0]) begin
            entries_d[0] = value_q;
          end
          for (int i = 1; i < DEPTH; i++) begin
            if (!le[i]) begin
              entries_d[i] = le[i-1] ? value_q : entries_q[i-1];
            end
          end
          count_d  = count_q + CNT_W'(1);
          status_d = ST_DONE;
        end
      end
      OP_DELETE: begin
        if (count_q == '0) begin
          status_d = ST_RANGE;
        end else if (!hit_pre[DEPTH]) begin
          status_d = ST_NOT_FOUND;
        end else begin
          // Cells at or above the first match take their upper neighbour.
          for (int i = 0; i < DEPTH - 1; i++) begin
            if (hit_pre[i+1]) begin
              entries_d[i] = entries_q[i+1];
            end
          end
          count_d  = count_q - CNT_W'(1);
          status_d = ST_DONE;
        end
      end
      OP_READ: begin
        if (CNT_W'(index_q) < count_q) begin
          rdval_d  = entries_q[index_q];
          status_d = ST_DONE;
        end
      end
      default: begin
        status_d = ST_RANGE;
      end
    endcase
  end

  // Entry row and result register; these hold payload only.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      for (int i = 0; i < DEPTH; i++) begin
        entries_q[i] <= entries_d[i];
      end
      status_q  <= status_d;
      rdval_q   <= rdval_d;
      cnt_out_q <= count_d;
    end
  end

  // Fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  assign status_o     = status_q;
  assign read_value_o = rdval_q;
  assign count_o      = cnt_out_q;

endmodule

// File: rtl/sli_checker.sv
// Port checker for the sorted list block, bound to the top level.
// Depends on sli_pkg and sorted_list_insert_delete_assert.svh.
`include "sorted_list_insert_delete_assert.svh"

module sli_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [1:0]                          status_o,
  input logic signed [sli_pkg::VALUE_W-1:0]  read_value_o,
  input logic [sli_pkg::CNT_W-1:0]           count_o
);
  import sli_pkg::*;

  // A stalled result beat holds.
  `SLI_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(status_o) && $stable(read_value_o) && $stable(count_o), "stalled result changed")

  // An accepted beat is followed by an update cycle.
  `SLI_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "input taken during update")

  // A full report comes only with a full list.
  `SLI_ASSERT_NOW(a_full_count, clk_i, rst_ni, out_valid_o && (status_o == ST_FULL), count_o == CNT_W'(DEPTH), "full reported below depth")

  // The count never passes the depth.
  `SLI_ASSERT_NOW(a_count_max, clk_i, rst_ni, out_valid_o, count_o <= CNT_W'(DEPTH), "count above depth")

  // Read data is non-zero only on a done status.
  `SLI_ASSERT_NOW(a_read_zero, clk_i, rst_ni, out_valid_o && (read_value_o != '0), status_o == ST_DONE, "read data on failed beat")

endmodule

bind sorted_list_insert_delete sli_checker u_sli_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .status_o     (status_o),
  .read_value_o (read_value_o),
  .count_o      (count_o)
);

// File: sim/tb_top.sv
// Self-checking testbench for the sorted list block: a queue of operations feeds a
// clocked driver, and a clocked monitor checks each result beat against a shadow list.
// Depends on sli_pkg and sorted_list_insert_delete.
module tb_top;
  import sli_pkg::*;

  // Code that the block does not decode; it must answer with a range status.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_OPS  = 1500;
  localparam int IDLE_LIMIT  = 1000;
  localparam int TAIL_CYCLES = 16;
  localparam int REPORT_MAX  = 10;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic [1:0]                 opcode;
    logic signed [VALUE_W-1:0]  value;
    logic [INDEX_W-1:0]         index;
    int                         gap;
    bit                         drain;
  } list_op_t;

  typedef struct {
    status_e                    status;
    logic signed [VALUE_W-1:0]  read_value;
    logic [CNT_W-1:0]           count;
  } list_result_t;

  logic                        clk_i        = 1'b0;
  logic                        rst_ni       = 1'b0;
  logic                        in_valid_i   = 1'b0;
  logic                        in_stall_o;
  logic [1:0]                  opcode_i     = OP_INSERT;
  logic signed [VALUE_W-1:0]   value_i      = '0;
  logic [INDEX_W-1:0]          index_i      = '0;
  logic                        out_valid_o;
  logic                        out_stall_i  = 1'b0;
  logic [1:0]                  status_o;
  logic signed [VALUE_W-1:0]   read_value_o;
  logic [CNT_W-1:0]            count_o;

  list_op_t      op_queue[$];
  list_result_t  due_results[$];
  logic signed [VALUE_W-1:0] inserted_hist[$];

  // Shadow copy of the list, kept by the driver side.
  logic signed [VALUE_W-1:0] shadow_list [DEPTH];
  int                        shadow_count = 0;

  // Beat counters, updated with nonblocking assignments so that either side
  // reads settled values at an edge; the mismatch count uses blocking updates.
  int n_predicted = 0;
  int n_checked   = 0;
  int mismatches  = 0;
  int idle_cycles = 0;

  sorted_list_insert_delete uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .value_i      (value_i),
    .index_i      (index_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .read_value_o (read_value_o),
    .count_o      (count_o)
  );

  // Clock with a period of two units.
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Applies one operation to the shadow list and returns the result it should give.
  function automatic list_result_t sorted_list_apply(logic [1:0] op,
                                                     logic signed [VALUE_W-1:0] v,
                                                     logic [INDEX_W-1:0] idx);
    list_result_t r;
    int pos;
    int k;
    r.status     = ST_RANGE;
    r.read_value = '0;
    case (op)
      OP_INSERT: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // A value no greater than the head goes in front; otherwise after
          // every entry that is not greater than it.
          pos = 0;
          if (shadow_count != 0 && v > shadow_list[0]) begin
            pos = 1;
            while (pos < shadow_count && shadow_list[pos] <= v) pos++;
          end
          for (k = shadow_count; k > pos; k--) shadow_list[k] = shadow_list[k-1];
          shadow_list[pos] = v;
          shadow_count++;
          r.status = ST_DONE;
        end
      end
      OP_DELETE: begin
        if (shadow_count != 0) begin
          pos = 0;
          while (pos < shadow_count && shadow_list[pos] != v) pos++;
          if (pos >= shadow_count) begin
            r.status = ST_NOT_FOUND;
          end else begin
            for (k = pos; k + 1 < shadow_count; k++) shadow_list[k] = shadow_list[k+1];
            shadow_count--;
            r.status = ST_DONE;
          end
        end
      end
      OP_READ: begin
        if (int'(idx) < shadow_count) begin
          r.read_value = shadow_list[idx];
          r.status     = ST_DONE;
        end
      end
      default: begin
        r.status = ST_RANGE;
      end
    endcase
    r.count = CNT_W'(shadow_count);
    return r;
  endfunction

  task automatic add_op(logic [1:0] op, logic signed [VALUE_W-1:0] v,
                        logic [INDEX_W-1:0] idx, int gap, bit drain);
    list_op_t item;
    item.opcode = op;
    item.value  = v;
    item.index  = idx;
    item.gap    = gap;
    item.drain  = drain;
    op_queue.push_back(item);
    if (op == OP_INSERT) begin
      inserted_hist.push_back(v);
      if (inserted_hist.size() > 32) void'(inserted_hist.pop_front());
    end
  endtask

  // Values cluster on a small pool so that duplicates and hits on delete are common.
  function automatic logic signed [VALUE_W-1:0] pick_value(bit for_delete);
    logic signed [VALUE_W-1:0] pool [10];
    int r;
    pool = '{VAL_MIN, VAL_MIN + 1, -1000, -1, 0, 1, 7, 1000, VAL_MAX - 1, VAL_MAX};
    r = $urandom_range(0, 99);
    if (for_delete && inserted_hist.size() != 0 && r < 70)
      return inserted_hist[$urandom_range(0, inserted_hist.size() - 1)];
    if (r < 85) return pool[$urandom_range(0, 9)];
    return $urandom;
  endfunction

  task automatic build_stimulus();
    int i;
    int r;
    int phase;
    int gap;
    logic [1:0] op;
    // Directed part: empty list, unused code, front and tail inserts, duplicates,
    // reads past the end and deletes of absent and present values.
    add_op(OP_READ,   0,       4'd0,  $urandom_range(0, 3), 1'b0);
    add_op(OP_DELETE, 5,       4'd0,  $urandom_range(0, 3), 1'b0);
    add_op(OP_UNUSED, VAL_MAX, 4'd15, $urandom_range(0, 3), 1'b0);
    add_op(OP_INSERT, 0,       4'd0,  $urandom_range(0, 3), 1'b0);
    add_op(OP_INSERT, VAL_MIN, 4'd15, $urandom_range(0, 3), 1'b0);
    add_op(OP_INSERT, VAL_MAX, 4'd0,  $urandom_range(0, 3), 1'b0);
    add_op(OP_INSERT, 0,       4'd0,  $urandom_range(0, 3), 1'b0);
    add_op(OP_INSERT, -1,      4'd0,  $urandom_range(0, 3), 1'b0);
    add_op(OP_INSERT, 1,       4'd0,  $urandom_range(0, 3), 1'b0);
    add_op(OP_READ,   0,       4'd0,  $urandom_range(0, 3), 1'b0);
    add_op(OP_READ,   0,       4'd5,  $urandom_range(0, 3), 1'b0);
    add_op(OP_READ,   0,       4'd6,  $urandom_range(0, 3), 1'b0);
    add_op(OP_READ,   0,       4'd15, $urandom_range(0, 3), 1'b0);
    add_op(OP_DELETE, 12345,   4'd0,  $urandom_range(0, 3), 1'b0);
    add_op(OP_DELETE, 0,       4'd0,  $urandom_range(0, 3), 1'b0);
    add_op(OP_DELETE, VAL_MIN, 4'd0,  $urandom_range(0, 3), 1'b0);
    add_op(OP_DELETE, VAL_MAX, 4'd0,  $urandom_range(0, 3), 1'b0);
    add_op(OP_UNUSED, 0,       4'd0,  $urandom_range(0, 3), 1'b0);
    add_op(OP_INSERT, 32'sh5555_5555, 4'd0, $urandom_range(0, 3), 1'b0);
    add_op(OP_INSERT, 32'shaaaa_aaaa, 4'd0, $urandom_range(0, 3), 1'b0);
    add_op(OP_READ,   0,       4'd2,  $urandom_range(0, 3), 1'b0);
    // Random part: fill, drain and mixed phases so that the list runs from
    // empty to full and back many times.
    for (i = 0; i < RANDOM_OPS; i++) begin
      phase = (i / 60) % 3;
      r = $urandom_range(0, 99);
      if (r < 5) op = OP_UNUSED;
      else if (r < 25) op = OP_READ;
      else if (phase == 0) op = (r < 85) ? OP_INSERT : OP_DELETE;
      else if (phase == 1) op = (r < 40) ? OP_INSERT : OP_DELETE;
      else op = (r < 62) ? OP_INSERT : OP_DELETE;
      // Every fourth stretch of a hundred beats runs without gaps.
      gap = ((i / 100) % 4 == 1) ? 0 : $urandom_range(0, 3);
      add_op(op, pick_value(op == OP_DELETE), 4'($urandom_range(0, 15)), gap,
             (i % 150) == 0);
    end
  endtask

  // Driver: predicts each accepted beat and presents the next operation.
  always @(posedge clk_i or negedge rst_ni) begin
    list_op_t item;
    bit took;
    bit armed;
    int wait_left;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      opcode_i    <= OP_INSERT;
      value_i     <= '0;
      index_i     <= '0;
      n_predicted <= 0;
      armed       = 1'b0;
      wait_left   = 0;
    end else begin
      took = in_valid_i && !in_stall_o;
      if (took) begin
        due_results.push_back(sorted_list_apply(opcode_i, value_i, index_i));
        n_predicted <= n_predicted + 1;
      end
      if (!in_valid_i || took) begin
        if (op_queue.size() == 0) begin
          in_valid_i <= 1'b0;
        end else begin
          if (!armed) begin
            wait_left = op_queue[0].gap;
            armed     = 1'b1;
          end
          if (wait_left > 0) begin
            wait_left--;
            in_valid_i <= 1'b0;
          end else if (op_queue[0].drain && (took || n_predicted != n_checked)) begin
            // Hold off until every outstanding result has come back.
            in_valid_i <= 1'b0;
          end else begin
            item = op_queue.pop_front();
            armed = 1'b0;
            in_valid_i <= 1'b1;
            opcode_i   <= item.opcode;
            value_i    <= item.value;
            index_i    <= item.index;
          end
        end
      end
    end
  end

  task automatic report_field(string field, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
    if (mismatches < REPORT_MAX)
      $display("beat %0d: %s expected %0h, got %0h", n_checked, field, want, got);
    mismatches++;
  endtask

  // Monitor: checks each result beat and draws a stall for the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want;
    int hold_next;
    int hold_left;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      n_checked   <= 0;
      hold_left   = 0;
    end else begin
      hold_next = hold_left;
      if (out_valid_o && !out_stall_i) begin
        if (n_checked == n_predicted) begin
          if (mismatches < REPORT_MAX)
            $display("beat %0d: result with no operation outstanding", n_checked);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          if (status_o !== want.status)
            report_field("status", VALUE_W'(want.status), VALUE_W'(status_o));
          if (read_value_o !== want.read_value)
            report_field("read_value", want.read_value, read_value_o);
          if (count_o !== want.count)
            report_field("count", VALUE_W'(want.count), VALUE_W'(count_o));
          n_checked <= n_checked + 1;
        end
        hold_next = ((n_checked / 128) % 4 == 3) ? 0 : $urandom_range(0, 3);
      end
      if (hold_next > 0) begin
        out_stall_i <= 1'b1;
        hold_left   = hold_next - 1;
      end else begin
        out_stall_i <= 1'b0;
        hold_left   = 0;
      end
    end
  end

  // Watchdog count of cycles in which neither channel moves a beat.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Run control: stimulus, reset, wait for the last result, then the verdict.
  initial begin
    int tail;
    bit timed_out;
    build_stimulus();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    timed_out = 1'b0;
    do begin
      @(negedge clk_i);
      timed_out = idle_cycles >= IDLE_LIMIT;
    end while (!timed_out &&
               !(op_queue.size() == 0 && !in_valid_i && n_predicted == n_checked));
    tail = 0;
    while (!timed_out && tail < TAIL_CYCLES) begin
      @(negedge clk_i);
      tail++;
    end
    if (timed_out || mismatches != 0 || n_predicted != n_checked) begin
      $display("Mismatches found");
    end else begin
      $display("No mismatches found");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/sli_pkg.sv
rtl/sli_ctrl.sv
rtl/sli_datapath.sv
rtl/sorted_list_insert_delete.sv
rtl/sli_checker.sv
sim/tb_top.sv
